// ===== rtl/core/wavelet_lift_2d_gated_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the wavelet lifting block
// Concurrent checks clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WAVELET_LIFT_2D_GATED_MACROS_SVH
`define WAVELET_LIFT_2D_GATED_MACROS_SVH
`ifndef SYNTHESIS
`define WL_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication check failed");
`define WL_ASSERT_NEVER(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("forbidden condition seen");
`else
`define WL_ASSERT_IMPLIES(lbl, ante, cons)
`define WL_ASSERT_NEVER(lbl, expr)
`endif
`endif

// ===== rtl/core/wlift_pkg.sv =====
// ----------------------------------------------------------------------------
// wlift_pkg
// Constants and arithmetic helpers for the 2D 5/3 lifting wavelet block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package wlift_pkg;
   localparam int MaxLog2   = 8;
   localparam int AddrW     = 2 * MaxLog2;
   localparam int PlaneDepth = 1 << AddrW;
   localparam int SideW     = MaxLog2;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic REG_SIZE_LOG2 = 1'b0;
   localparam logic REG_DETAIL_GATE = 1'b1;

   localparam logic PASS_ROW = 1'b0;
   localparam logic PASS_COL = 1'b1;

   // truncate toward zero
   function automatic logic signed [16:0] div2(input logic signed [16:0] v);
      logic signed [16:0] t;
      t = v + {16'b0, v[16]};
      return t >>> 1;
   endfunction

   function automatic logic signed [16:0] div4(input logic signed [16:0] v);
      logic signed [16:0] t;
      t = v + {15'b0, v[16], v[16]};
      return t >>> 2;
   endfunction

   function automatic logic [AddrW-1:0] addr_of(input logic [SideW-1:0] hi,
                                                input logic [SideW-1:0] lo,
                                                input logic [3:0] k);
      return ({{SideW{1'b0}}, hi} << k) | {{SideW{1'b0}}, lo};
   endfunction
endpackage
`default_nettype wire

// ===== rtl/core/wavelet_lift_2d_gated.sv =====
// Load: one request per cycle; the last sample starts the transform.
// Transform: per level, a row pass then a column pass, each over d lines (d = region
//   side, halved per level), each line read sample by sample through the one read
//   port; a closing drain state then marks the plane ready.
// Read: a request passes the plane memory read register, then the output register.
// Reset clears state, load/read counters, flags and gate, sets size to 8; memories stay undefined.
`timescale 1ns / 1ps
`default_nettype none
`include "wavelet_lift_2d_gated_macros.svh"
// ----------------------------------------------------------------------------
// wavelet_lift_2d_gated
// Plane loader, in-place multi-level 2D 5/3 lifting with gated highpass, readout.
// ----------------------------------------------------------------------------
module wavelet_lift_2d_gated (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] sample
   input  wire logic        req_tuser,   // [0] cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [15:0] coefficient
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic [11:0] csr_wdata
);
   import wlift_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RD    = 2'd1;
   localparam logic [1:0] ST_XFORM = 2'd2;
   localparam logic [1:0] ST_DRAIN = 2'd3;

   logic [15:0] plane_mem   [0:PlaneDepth-1];
   logic [15:0] scratch_mem [0:PlaneDepth-1];

   logic [1:0]  state_ff, state_in;
   logic [AddrW-1:0] load_cnt_ff, load_cnt_in, read_cnt_ff, read_cnt_in;
   logic        ready_plane_ff, ready_plane_in;
   logic [3:0]  size_ff, size_in;
   logic [11:0] gate_ff, gate_in;
   logic [2:0]  lvl_ff, lvl_in;
   logic [3:0]  dl_ff, dl_in;
   logic        pass_ff, pass_in;
   logic [7:0]  line_ff, line_in;
   logic [8:0]  j_ff, j_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [15:0] rsp_data_ff, rsp_data_in;
   logic        last_pend_ff, last_pend_in;
   logic        pv_ff, pv_in;
   logic [8:0]  pj_ff;
   logic [7:0]  pline_ff;
   logic        ppass_ff;
   logic [3:0]  pdl_ff;
   logic [2:0]  plvl_ff;
   logic [15:0] e_ff, o_ff, hpp_ff;
   logic [7:0]  gated_ff;
   logic [15:0] plane_q_ff, scratch_q_ff;

   logic [3:0]  k_w;
   logic [16:0] total_w;
   logic [AddrW-1:0] last_idx_w, load_idx_w;
   logic [8:0]  d_w, d_q;
   logic [7:0]  len_q;
   logic        accept;
   logic        plane_re, scratch_re, load_we, proc_we, proc_plane_we, proc_scr_we;
   logic [AddrW-1:0] plane_raddr, scratch_raddr, load_waddr, proc_waddr;
   logic [7:0]  wr_idx;
   logic [15:0] wr_data, x_w, hp_w, lp_w;
   logic signed [16:0] hp17, lp17, h17;
   logic signed [8:0]  hs;
   logic [11:0] gate_lvl;
   logic signed [12:0] hs13, gs13;
   logic [7:0]  g_w;

   assign k_w = (size_ff < 4'd2) ? 4'd2 :
                (size_ff > 4'(MaxLog2)) ? 4'(MaxLog2) : size_ff;
   assign total_w    = 17'd1 << {k_w, 1'b0};
   assign last_idx_w = AddrW'(total_w - 17'd1);
   assign d_w   = 9'd1 << dl_ff;
   assign d_q   = 9'd1 << pdl_ff;
   assign len_q = 8'(d_q >> 1);
   assign accept = req_tvalid & req_tready;
   assign load_idx_w = ready_plane_ff ? '0 : load_cnt_ff;

   // ---------------- lifting datapath on returned line data ----------------
   assign x_w = (ppass_ff == PASS_ROW) ? plane_q_ff : scratch_q_ff;

   always_comb begin
      if (pj_ff == d_q)
         hp17 = {o_ff[15], o_ff} - {e_ff[15], e_ff};
      else
         hp17 = {o_ff[15], o_ff} - div2({e_ff[15], e_ff} + {x_w[15], x_w});
      hp_w = hp17[15:0];
      if (pj_ff == 9'd2)
         lp17 = {e_ff[15], e_ff} + div2({hp_w[15], hp_w});
      else
         lp17 = {e_ff[15], e_ff} + div4({hp_w[15], hp_w} + {hpp_ff[15], hpp_ff});
      lp_w = lp17[15:0];
      h17 = div2({hp_w[15], hp_w});
      if (h17 < -17'sd128)
         hs = -9'sd128;
      else if (h17 > 17'sd127)
         hs = 9'sd127;
      else
         hs = h17[8:0];
      gate_lvl = gate_ff >> ({1'b0, plvl_ff} + 4'd5);
      hs13 = {{4{hs[8]}}, hs};
      gs13 = $signed({1'b0, gate_lvl});
      // dead zone: drop small details
      if (hs13 > -gs13 && hs13 < gs13)
         g_w = 8'd0;
      else
         g_w = hs[7:0];
   end

   always_comb begin
      proc_we = pv_ff && ((!pj_ff[0] && pj_ff != 9'd0) || (pj_ff[0] && pj_ff >= 9'd3));
      if (pj_ff[0]) begin
         wr_idx  = 8'(len_q + pj_ff[8:1] - 8'd1);
         wr_data = {{8{gated_ff[7]}}, gated_ff};
      end else begin
         wr_idx  = 8'(pj_ff[8:1] - 8'd1);
         wr_data = lp_w;
      end
      proc_waddr = (ppass_ff == PASS_ROW) ? addr_of(pline_ff, wr_idx, k_w)
                                          : addr_of(wr_idx, pline_ff, k_w);
      proc_scr_we   = proc_we && (ppass_ff == PASS_ROW);
      proc_plane_we = proc_we && (ppass_ff == PASS_COL);
   end

   // ---------------- control ----------------
   always_comb begin
      state_in = state_ff;
      load_cnt_in = load_cnt_ff;
      read_cnt_in = read_cnt_ff;
      ready_plane_in = ready_plane_ff;
      size_in = size_ff;
      gate_in = gate_ff;
      lvl_in = lvl_ff;
      dl_in = dl_ff;
      pass_in = pass_ff;
      line_in = line_ff;
      j_in = j_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_last_in = rsp_last_ff;
      rsp_data_in = rsp_data_ff;
      last_pend_in = last_pend_ff;
      pv_in = 1'b0;
      plane_re = 1'b0;
      scratch_re = 1'b0;
      load_we = 1'b0;
      plane_raddr = read_cnt_ff;
      scratch_raddr = '0;
      load_waddr = load_idx_w;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == CMD_LOAD) begin
                  load_we = 1'b1;
                  ready_plane_in = 1'b0;
                  read_cnt_in = '0;
                  if (load_idx_w == last_idx_w) begin
                     load_cnt_in = '0;
                     state_in = ST_XFORM;
                     lvl_in = 3'd0;
                     dl_in = k_w;
                     pass_in = PASS_ROW;
                     line_in = 8'd0;
                     j_in = 9'd0;
                  end else begin
                     load_cnt_in = load_idx_w + 1'b1;
                  end
               end else if (ready_plane_ff) begin
                  plane_re = 1'b1;
                  last_pend_in = (read_cnt_ff == last_idx_w);
                  if (read_cnt_ff == last_idx_w) begin
                     read_cnt_in = '0;
                     ready_plane_in = 1'b0;
                  end else begin
                     read_cnt_in = read_cnt_ff + 1'b1;
                  end
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            // hold the read data until the output register frees up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = plane_q_ff;
               rsp_last_in = last_pend_ff;
               state_in = ST_IDLE;
            end
         end
         ST_XFORM: begin
            pv_in = 1'b1;
            if (j_ff < d_w) begin
               if (pass_ff == PASS_ROW) begin
                  plane_re = 1'b1;
                  plane_raddr = addr_of(line_ff, j_ff[7:0], k_w);
               end else begin
                  scratch_re = 1'b1;
                  scratch_raddr = addr_of(j_ff[7:0], line_ff, k_w);
               end
            end
            if (j_ff == d_w + 9'd1) begin
               j_in = 9'd0;
               if (line_ff == 8'(d_w - 9'd1)) begin
                  line_in = 8'd0;
                  if (pass_ff == PASS_COL) begin
                     pass_in = PASS_ROW;
                     lvl_in = lvl_ff + 3'd1;
                     dl_in = dl_ff - 4'd1;
                     if (dl_ff == 4'd2)
                        state_in = ST_DRAIN;
                  end else begin
                     pass_in = PASS_COL;
                  end
               end else begin
                  line_in = line_ff + 8'd1;
               end
            end else begin
               j_in = j_ff + 9'd1;
            end
         end
         ST_DRAIN: begin
            ready_plane_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (csr_we) begin
         if (csr_addr == REG_SIZE_LOG2) begin
            size_in = csr_wdata[3:0];
            load_cnt_in = '0;
            read_cnt_in = '0;
            ready_plane_in = 1'b0;
         end else begin
            gate_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         load_cnt_ff <= '0;
         read_cnt_ff <= '0;
         ready_plane_ff <= 1'b0;
         size_ff <= 4'd8;
         gate_ff <= 12'd0;
         rsp_valid_ff <= 1'b0;
         pv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         load_cnt_ff <= load_cnt_in;
         read_cnt_ff <= read_cnt_in;
         ready_plane_ff <= ready_plane_in;
         size_ff <= size_in;
         gate_ff <= gate_in;
         rsp_valid_ff <= rsp_valid_in;
         pv_ff <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff <= lvl_in;
      dl_ff <= dl_in;
      pass_ff <= pass_in;
      line_ff <= line_in;
      j_ff <= j_in;
      rsp_last_ff <= rsp_last_in;
      rsp_data_ff <= rsp_data_in;
      last_pend_ff <= last_pend_in;
      pj_ff <= j_ff;
      pline_ff <= line_ff;
      ppass_ff <= pass_ff;
      pdl_ff <= dl_ff;
      plvl_ff <= lvl_ff;
      if (pv_ff) begin
         if (!pj_ff[0]) begin
            e_ff <= x_w;
            if (pj_ff != 9'd0) begin
               hpp_ff <= hp_w;
               gated_ff <= g_w;
            end
         end else begin
            o_ff <= x_w;
         end
      end
   end

   // ---------------- memories ----------------
   always_ff @(posedge clock) begin
      if (load_we)
         plane_mem[load_waddr] <= req_tdata;
      else if (proc_plane_we)
         plane_mem[proc_waddr] <= wr_data;
      if (plane_re)
         plane_q_ff <= plane_mem[plane_raddr];
   end

   always_ff @(posedge clock) begin
      if (proc_scr_we)
         scratch_mem[proc_waddr] <= wr_data;
      if (scratch_re)
         scratch_q_ff <= scratch_mem[scratch_raddr];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `WL_ASSERT_IMPLIES(a_xform_not_ready, state_ff == ST_XFORM, !ready_plane_ff)
   `WL_ASSERT_IMPLIES(a_rsp_after_read, $rose(rsp_valid_ff), $past(state_ff) == ST_RD)
   `WL_ASSERT_IMPLIES(a_write_in_region, proc_we, {1'b0, wr_idx} < d_q)
   `WL_ASSERT_NEVER(a_plane_one_writer, load_we && proc_plane_we)
endmodule
`default_nettype wire
